@@ hw/rtl/imubfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU burst frame checker package
// Shared widths, word positions, verdict codes and the CRC-32 word update.
// ----------------------------------------------------------------------------
package imubfc_pkg;

   localparam int FRAME_WORDS = 19;
   localparam int POS_W       = $clog2(FRAME_WORDS + 1);
   localparam int STORE_DEPTH = 16;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   typedef logic [15:0]      word_type;
   typedef logic [31:0]      crc_type;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [1:0]       verdict_type;

   localparam pos_type POS_IDLE   = pos_type'(FRAME_WORDS);
   localparam pos_type POS_ID0    = pos_type'(0);
   localparam pos_type POS_ID1    = pos_type'(1);
   localparam pos_type POS_STATUS = pos_type'(2);
   localparam pos_type POS_COUNT  = pos_type'(FRAME_WORDS - 3);
   localparam pos_type POS_CRC_LO = pos_type'(FRAME_WORDS - 2);
   localparam pos_type POS_CRC_HI = pos_type'(FRAME_WORDS - 1);

   // Store slots, counted from the status word.
   localparam int SLOT_STATUS = 0;
   localparam int SLOT_TEMP   = 1;
   localparam int SLOT_ANG_X  = 2;
   localparam int SLOT_ANG_Y  = 4;
   localparam int SLOT_ANG_Z  = 6;
   localparam int SLOT_VEL_X  = 8;
   localparam int SLOT_VEL_Y  = 10;
   localparam int SLOT_VEL_Z  = 12;
   localparam int SLOT_COUNT  = FRAME_WORDS - 5;

   localparam crc_type  CRC_POLY = 32'hEDB8_8320;
   localparam crc_type  ALL_ONES = 32'hFFFF_FFFF;
   localparam word_type ID_RESET = 16'hC3C3;

   localparam verdict_type VERDICT_OK     = 2'd0;
   localparam verdict_type VERDICT_STALE  = 2'd1;
   localparam verdict_type VERDICT_BAD_ID = 2'd2;
   localparam verdict_type VERDICT_BAD_CRC = 2'd3;

   // Reflected CRC-32 over one word, low byte first. Because the update is
   // linear, feeding the whole word at once and shifting 16 times is the same
   // as two byte steps; synthesis flattens it into a plain XOR network.
   function automatic crc_type crc_word(crc_type crc, word_type w);
      crc_type c;
      c = crc ^ {16'h0000, w};
      for (int b = 0; b < 16; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/imubfc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU burst frame checker channels
// Valid/ready channels for burst words, check results and the ID register.
// ----------------------------------------------------------------------------
interface imubfc_req_if import imubfc_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type bus_word;
   logic     frame_start;

   modport source (output valid, bus_word, frame_start, input ready);
   modport sink (input valid, bus_word, frame_start, output ready);
endinterface

interface imubfc_rsp_if import imubfc_pkg::*; ();
   logic               valid;
   logic               ready;
   verdict_type        verdict;
   word_type           status_word;
   logic signed [15:0] temperature_raw;
   logic signed [31:0] delta_angle_x;
   logic signed [31:0] delta_angle_y;
   logic signed [31:0] delta_angle_z;
   logic signed [31:0] delta_vel_x;
   logic signed [31:0] delta_vel_y;
   logic signed [31:0] delta_vel_z;
   word_type           sample_count;

   modport source (output valid, verdict, status_word, temperature_raw,
                   delta_angle_x, delta_angle_y, delta_angle_z,
                   delta_vel_x, delta_vel_y, delta_vel_z, sample_count,
                   input ready);
   modport sink (input valid, verdict, status_word, temperature_raw,
                 delta_angle_x, delta_angle_y, delta_angle_z,
                 delta_vel_x, delta_vel_y, delta_vel_z, sample_count,
                 output ready);
endinterface

interface imubfc_csr_if import imubfc_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type expected_burst_id;

   modport source (output valid, expected_burst_id, input ready);
   modport sink (input valid, expected_burst_id, output ready);
endinterface

@@ hw/rtl/imu_burst_frame_checker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU burst frame checker
// Unpacks a 19-word inertial-sensor burst, checks IDs, CRC-32 and count.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one 16-bit burst word per request; frame_start marks the
//   first ID word and restarts any burst in progress. Words arriving with no
//   burst open are dropped.
//   rsp_chan delivers one result per complete burst: the verdict and the
//   unpacked fields. It appears in the cycle after the CRC high word is taken.
//   csr_chan writes the expected burst ID; it is always ready and should be
//   written only while the block is idle.
// Throughput: one word per cycle. Each word's CRC step, ID compare and store
//   write finish in the cycle it is taken; the final verdict is loaded into
//   the result register directly.
// Stalls: the result register is a single slot. While it is full and
//   rsp_chan.ready is low, req_chan.ready drops; a result taken in the same
//   cycle frees the slot for the next request.
// Reset: the block waits for a frame start, the ID register returns to
//   0xC3C3 and the remembered sample count is forgotten.
// ----------------------------------------------------------------------------
module imu_burst_frame_checker_top
   import imubfc_pkg::*;
(
   input logic          clock,
   input logic          reset,
   imubfc_req_if.sink   req_chan,
   imubfc_rsp_if.source rsp_chan,
   imubfc_csr_if.sink   csr_chan
);

   word_type    exp_id_ff, exp_id_in;
   pos_type     pos_ff, pos_in;
   crc_type     crc_ff, crc_in;
   logic        id_ok_ff, id_ok_in;
   word_type    store_ff [STORE_DEPTH];
   word_type    crc_lo_ff;
   word_type    last_cnt_ff, last_cnt_in;
   logic        have_last_ff, have_last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type verdict_ff, verdict_in;

   logic        req_take;
   logic        last_word;
   pos_type     pos_cur;
   crc_type     crc_cur;
   word_type    w;
   word_type    count;
   logic        id_eq;
   logic [STORE_AW-1:0] slot;

   assign w         = req_chan.bus_word;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take  = req_chan.valid && req_chan.ready;
   assign pos_cur   = req_chan.frame_start ? POS_ID0 : pos_ff;
   assign crc_cur   = req_chan.frame_start ? ALL_ONES : crc_ff;
   assign last_word = req_take && (pos_cur == POS_CRC_HI);
   assign id_eq     = (w == exp_id_ff);
   assign count     = store_ff[SLOT_COUNT];
   assign slot      = STORE_AW'(pos_cur - POS_STATUS);

   assign csr_chan.ready = 1'b1;

   always_comb begin
      exp_id_in    = exp_id_ff;
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      id_ok_in     = id_ok_ff;
      last_cnt_in  = last_cnt_ff;
      have_last_in = have_last_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      if (csr_chan.valid) begin
         exp_id_in = csr_chan.expected_burst_id;
      end

      if (req_take && (pos_cur < POS_IDLE)) begin
         pos_in = pos_cur + pos_type'(1);
         crc_in = crc_cur;
         if (pos_cur == POS_ID0) begin
            id_ok_in = id_eq;
         end else if (pos_cur == POS_ID1) begin
            id_ok_in = id_ok_ff && id_eq;
         end else if (pos_cur <= POS_COUNT) begin
            crc_in = crc_word(crc_cur, w);
         end
      end

      if (last_word) begin
         pos_in       = POS_IDLE;
         crc_in       = ALL_ONES;
         rsp_valid_in = 1'b1;
         priority if (have_last_ff && (count == last_cnt_ff)) begin
            verdict_in = VERDICT_STALE;
         end else if (!id_ok_ff) begin
            verdict_in = VERDICT_BAD_ID;
         end else if ((crc_ff ^ ALL_ONES) != {w, crc_lo_ff}) begin
            verdict_in = VERDICT_BAD_CRC;
         end else begin
            verdict_in   = VERDICT_OK;
            last_cnt_in  = count;
            have_last_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_id_ff    <= ID_RESET;
         pos_ff       <= POS_IDLE;
         crc_ff       <= ALL_ONES;
         id_ok_ff     <= 1'b0;
         last_cnt_ff  <= '0;
         have_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         verdict_ff   <= VERDICT_OK;
      end else begin
         exp_id_ff    <= exp_id_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         id_ok_ff     <= id_ok_in;
         last_cnt_ff  <= last_cnt_in;
         have_last_ff <= have_last_in;
         rsp_valid_ff <= rsp_valid_in;
         verdict_ff   <= verdict_in;
      end
   end

   // Payload storage: burst fields and the captured result fields.
   always_ff @(posedge clock) begin
      if (req_take && (pos_cur >= POS_STATUS) && (pos_cur <= POS_COUNT)) begin
         store_ff[slot] <= w;
      end
      if (req_take && (pos_cur == POS_CRC_LO)) begin
         crc_lo_ff <= w;
      end
      if (last_word) begin
         rsp_chan.status_word     <= store_ff[SLOT_STATUS];
         rsp_chan.temperature_raw <= $signed(store_ff[SLOT_TEMP]);
         rsp_chan.delta_angle_x   <= $signed({store_ff[SLOT_ANG_X+1], store_ff[SLOT_ANG_X]});
         rsp_chan.delta_angle_y   <= $signed({store_ff[SLOT_ANG_Y+1], store_ff[SLOT_ANG_Y]});
         rsp_chan.delta_angle_z   <= $signed({store_ff[SLOT_ANG_Z+1], store_ff[SLOT_ANG_Z]});
         rsp_chan.delta_vel_x     <= $signed({store_ff[SLOT_VEL_X+1], store_ff[SLOT_VEL_X]});
         rsp_chan.delta_vel_y     <= $signed({store_ff[SLOT_VEL_Y+1], store_ff[SLOT_VEL_Y]});
         rsp_chan.delta_vel_z     <= $signed({store_ff[SLOT_VEL_Z+1], store_ff[SLOT_VEL_Z]});
         rsp_chan.sample_count    <= count;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.verdict = verdict_ff;

   // An idle checker always holds a fresh CRC seed.
   a_idle_crc_seed: assert property (@(posedge clock) disable iff (reset)
      (pos_ff == POS_IDLE) |-> (crc_ff == ALL_ONES))
      else $error("CRC not reseeded while idle");

   a_last_word_closes: assert property (@(posedge clock) disable iff (reset)
      last_word |=> (pos_ff == POS_IDLE) && rsp_valid_ff)
      else $error("Burst did not close after the CRC high word");

   a_count_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      !$stable(last_cnt_ff) |-> rsp_valid_ff && (verdict_ff == VERDICT_OK))
      else $error("Sample count remembered without an ok verdict");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_IDLE)
      else $error("Word position out of range");

endmodule
